>>> design/irr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irr_pkg
// Shared types and codes of the input report ring with pending reads.
// ----------------------------------------------------------------------------
package irr_pkg;

    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_READ   = 2'd1,
        OP_CANCEL = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_SUCCESS   = 3'd0,
        ST_PENDING   = 3'd1,
        ST_CANCELLED = 3'd2,
        ST_DELETE    = 3'd3,
        ST_SMALL     = 3'd4,
        ST_NOROOM    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_QUEUE_LENGTH = 2'd0,
        REG_POLLED_MODE  = 2'd1,
        REG_DEV_REMOVED  = 2'd2,
        REG_MIN_READ_LEN = 2'd3
    } reg_idx_t;

    localparam logic [9:0] QLEN_RESET = 10'd32;
    localparam logic [9:0] QLEN_MIN   = 10'd2;

    // One accepted request as handed from the front to the back part.
    typedef struct packed {
        op_t         op;
        logic [15:0] handle;
        logic [11:0] length;
        logic [7:0]  id;
        logic [11:0] buflen;
    } req_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  id;
        status_t     status;
        logic [15:0] handle;
        logic [11:0] length;
        logic        last;
    } res_t;

endpackage

>>> design/irr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irr_front
// Takes requests from the input port into a short queue for the back part.
// ----------------------------------------------------------------------------
module irr_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  irr_pkg::req_t in_req,
    output logic          req_valid,
    input  logic          req_take,
    output irr_pkg::req_t req_out
);

    irr_pkg::req_t q_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;

    logic do_push;
    logic do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req_out   = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = req_take && req_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

>>> design/irr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irr_back
// Carries out one request at a time: ring and waiting list, one result a step.
// ----------------------------------------------------------------------------
module irr_back
#(
    parameter int RING_DEPTH = 512,
    parameter int WAIT_DEPTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_take,
    input  irr_pkg::req_t req_in,
    input  logic [9:0]    queue_length,
    input  logic          qlen_clear,
    input  logic          polled_mode,
    input  logic          device_removed,
    input  logic [11:0]   min_read_length,
    output logic          res_valid,
    input  logic          res_take,
    output irr_pkg::res_t res_out
);

    localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int WW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WC = $clog2(WAIT_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SHIFT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]   ring_h [RING_DEPTH];
    logic [11:0]   ring_l [RING_DEPTH];
    logic [15:0]   rd_h_reg;
    logic [11:0]   rd_l_reg;
    logic [RW-1:0] head_reg, head_next;
    logic [RW-1:0] tail_reg, tail_next;
    logic [9:0]    count_reg, count_next;

    logic [7:0]    wait_reg [WAIT_DEPTH];
    logic [WC-1:0] wcnt_reg, wcnt_next;
    logic [WC-1:0] shift_reg, shift_next;

    irr_pkg::req_t req_reg, req_next;
    irr_pkg::res_t res_reg, res_next;
    logic          more_reg, more_next;

    logic          ring_we;
    logic          wait_we;
    logic [WW-1:0] wait_wa;
    logic          do_shift;

    logic [RW-1:0] head_inc;
    logic [RW-1:0] tail_inc;
    logic          cancel_hit;
    logic [WW-1:0] cancel_pos;
    logic          ring_has;
    logic          wait_full;

    function automatic logic [RW-1:0] ring_step(input logic [RW-1:0] i,
                                                input logic [9:0] qlen);
        logic [RW:0] n;
        n = {1'b0, i} + 1'b1;
        if (int'(n) >= int'(qlen) || int'(n) >= RING_DEPTH)
            ring_step = '0;
        else
            ring_step = n[RW-1:0];
    endfunction

    assign head_inc  = ring_step(head_reg, queue_length);
    assign tail_inc  = ring_step(tail_reg, queue_length);
    assign ring_has  = (count_reg != 10'd0);
    assign wait_full = (wcnt_reg >= WC'(WAIT_DEPTH));

    // Oldest matching waiting tag, found over the entries in parallel.
    always_comb
    begin
        cancel_hit = 1'b0;
        cancel_pos = '0;
        for (int i = WAIT_DEPTH - 1; i >= 0; i--)
        begin
            if (WC'(i) < wcnt_reg && wait_reg[i] == req_reg.id)
            begin
                cancel_hit = 1'b1;
                cancel_pos = WW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_h[tail_reg] <= req_reg.handle;
            ring_l[tail_reg] <= min_read_length;
        end
        rd_h_reg <= ring_h[head_reg];
        rd_l_reg <= ring_l[head_reg];
    end

    // The entries from the removed position upwards move down by one.
    always_ff @(posedge clk)
    begin
        if (do_shift)
        begin
            for (int i = 0; i < WAIT_DEPTH - 1; i++)
            begin
                if (WC'(i) >= shift_next)
                    wait_reg[i] <= wait_reg[i+1];
            end
        end
        else if (wait_we)
        begin
            wait_reg[wait_wa] <= req_reg.id;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        wcnt_next  = wcnt_reg;
        shift_next = shift_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        more_next  = more_reg;
        req_take   = 1'b0;
        ring_we    = 1'b0;
        wait_we    = 1'b0;
        wait_wa    = wcnt_reg[WW-1:0];
        do_shift   = 1'b0;
        res_valid  = (state_reg == S_OUT);
        res_out    = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_take   = 1'b1;
                    req_next   = req_in;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // Ring read data is registered by now for the current head.
                state_next = S_EXEC;
                if (req_reg.op == irr_pkg::OP_REPORT && !device_removed &&
                    !polled_mode)
                begin
                    ring_we   = 1'b1;
                    tail_next = tail_inc;
                    if (count_reg >= queue_length)
                        head_next = head_inc;
                    else
                        count_next = count_reg + 10'd1;
                    if (wcnt_reg == '0)
                        state_next = S_IDLE;
                    else
                        state_next = S_READ;
                    // Re-read the ring so the served entry reflects this write.
                    req_next.op = irr_pkg::OP_FLUSH;
                    more_next   = 1'b1;
                    if (wcnt_reg == '0)
                        more_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                res_next = '0;
                res_next.id = req_reg.id;
                res_next.last = 1'b1;
                state_next = S_OUT;
                case (req_reg.op)
                    irr_pkg::OP_REPORT:
                    begin
                        // Polled mode only; serve the oldest waiting read.
                        if (device_removed || wcnt_reg == '0)
                            state_next = S_IDLE;
                        else
                        begin
                            res_next.id = wait_reg[0];
                            res_next.status = irr_pkg::ST_SUCCESS;
                            if (ring_has)
                            begin
                                res_next.handle = rd_h_reg;
                                res_next.length = rd_l_reg;
                                head_next  = head_inc;
                                count_next = count_reg - 10'd1;
                            end
                            else
                            begin
                                res_next.handle = req_reg.handle;
                                res_next.length = req_reg.length;
                            end
                            res_next.last = (wcnt_reg == WC'(1));
                            shift_next = '0;
                            wcnt_next  = wcnt_reg - WC'(1);
                            do_shift   = 1'b1;
                        end
                    end
                    irr_pkg::OP_READ:
                    begin
                        if (device_removed)
                            res_next.status = irr_pkg::ST_DELETE;
                        else if (req_reg.buflen < min_read_length)
                            res_next.status = irr_pkg::ST_SMALL;
                        else if (ring_has)
                        begin
                            res_next.status = irr_pkg::ST_SUCCESS;
                            res_next.handle = rd_h_reg;
                            res_next.length = rd_l_reg;
                            head_next  = head_inc;
                            count_next = count_reg - 10'd1;
                        end
                        else if (wait_full)
                            res_next.status = irr_pkg::ST_NOROOM;
                        else
                        begin
                            res_next.status = irr_pkg::ST_PENDING;
                            wait_we   = 1'b1;
                            wcnt_next = wcnt_reg + WC'(1);
                        end
                    end
                    irr_pkg::OP_CANCEL:
                    begin
                        if (cancel_hit)
                        begin
                            res_next.status = irr_pkg::ST_CANCELLED;
                            shift_next = WC'(cancel_pos);
                            wcnt_next  = wcnt_reg - WC'(1);
                            do_shift   = 1'b1;
                        end
                        else
                            state_next = S_IDLE;
                    end
                    default:
                    begin
                        // Flush, or a non-polled report serving one read.
                        if (wcnt_reg == '0)
                            state_next = S_IDLE;
                        else if (more_reg)
                        begin
                            res_next.id = wait_reg[0];
                            res_next.status = irr_pkg::ST_SUCCESS;
                            res_next.handle = rd_h_reg;
                            res_next.length = rd_l_reg;
                            head_next  = head_inc;
                            count_next = count_reg - 10'd1;
                            shift_next = '0;
                            wcnt_next  = wcnt_reg - WC'(1);
                            do_shift   = 1'b1;
                        end
                        else
                        begin
                            res_next.id = wait_reg[0];
                            res_next.status = irr_pkg::ST_DELETE;
                            res_next.last = (wcnt_reg == WC'(1));
                            shift_next = '0;
                            wcnt_next  = wcnt_reg - WC'(1);
                            do_shift   = 1'b1;
                        end
                    end
                endcase
            end
            S_SHIFT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_take)
                begin
                    if (res_reg.last || more_reg)
                    begin
                        more_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (qlen_clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            wcnt_reg  <= '0;
            shift_reg <= '0;
            more_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            wcnt_reg  <= wcnt_next;
            shift_reg <= shift_next;
            more_reg  <= more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

endmodule

>>> design/input_report_ring_with_pending_reads.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_report_ring_with_pending_reads
// Report ring with a FIFO of waiting reads, fed through a request queue.
// ----------------------------------------------------------------------------
// A request is taken into a two-entry queue and then carried out by a
// sequencer that reads the report ring memory through one registered port.
// A read, or a cancel that finds its tag, passes through the read, execute
// and output states, and its result waits in the output register until
// popped; a cancel that finds no tag gives no result. A report with
// nothing waiting gives no result; a report that serves a waiting read
// passes through the read state once more, as the ring is read again
// after the write. A flush or a polled report gives one result per
// waiting read, each through the read, execute and output states. Results
// are held in the output register until popped, which stalls the
// sequencer while the request queue fills behind it.
module input_report_ring_with_pending_reads
#(
    parameter int RING_DEPTH = 512,
    parameter int WAIT_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [15:0] report_handle,
    input  logic [11:0] report_length,
    input  logic [7:0]  read_id,
    input  logic [11:0] read_buffer_length,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  done_read_id,
    output logic [2:0]  status,
    output logic [15:0] out_handle,
    output logic [11:0] out_length,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    irr_pkg::req_t in_req;
    irr_pkg::req_t req_q;
    irr_pkg::res_t res;
    logic          req_valid;
    logic          req_take;
    logic          res_valid;

    logic [9:0]  qlen_reg;
    logic        polled_reg;
    logic        removed_reg;
    logic [11:0] minlen_reg;
    logic        qlen_clear;
    logic        cfg_we;

    assign in_req.op     = irr_pkg::op_t'(operation);
    assign in_req.handle = report_handle;
    assign in_req.length = report_length;
    assign in_req.id     = read_id;
    assign in_req.buflen = read_buffer_length;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign qlen_clear = cfg_we && cfg_index == irr_pkg::REG_QUEUE_LENGTH &&
                        cfg_data[9:0] >= irr_pkg::QLEN_MIN &&
                        cfg_data[9:0] <= 10'(RING_DEPTH) &&
                        cfg_data[9:0] != qlen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg    <= irr_pkg::QLEN_RESET;
            polled_reg  <= 1'b0;
            removed_reg <= 1'b0;
            minlen_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                irr_pkg::REG_QUEUE_LENGTH:
                begin
                    if (qlen_clear)
                        qlen_reg <= cfg_data[9:0];
                end
                irr_pkg::REG_POLLED_MODE: polled_reg  <= cfg_data[0];
                irr_pkg::REG_DEV_REMOVED: removed_reg <= cfg_data[0];
                default:                  minlen_reg  <= cfg_data;
            endcase
        end
    end

    irr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_req    (in_req),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req_out   (req_q)
    );

    irr_back
    #(
        .RING_DEPTH (RING_DEPTH),
        .WAIT_DEPTH (WAIT_DEPTH)
    )
    u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_take        (req_take),
        .req_in          (req_q),
        .queue_length    (qlen_reg),
        .qlen_clear      (qlen_clear),
        .polled_mode     (polled_reg),
        .device_removed  (removed_reg),
        .min_read_length (minlen_reg),
        .res_valid       (res_valid),
        .res_take        (pop),
        .res_out         (res)
    );

    assign empty        = !res_valid;
    assign done_read_id = res.id;
    assign status       = res.status;
    assign out_handle   = res.handle;
    assign out_length   = res.length;
    assign last         = res.last;

    // A result on offer must not change until it is popped.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(done_read_id) && $stable(status)))
        else $error("result changed while waiting");

    // Non-success results carry no report.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != irr_pkg::ST_SUCCESS) |-> (out_handle == 16'd0))
        else $error("payload on failed result");

    // The ring length register stays in its legal range.
    a_qlen_range: assert property (@(posedge clk) disable iff (!rst_n)
        (qlen_reg >= irr_pkg::QLEN_MIN && qlen_reg <= 10'(RING_DEPTH)))
        else $error("queue length out of range");

endmodule

>>> verif/tb_input_report_ring_with_pending_reads.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the input report ring with pending reads
// Drives reports, reads, cancels and flushes through the request queue and
// checks every result against a behavioural copy of the ring, the waiting
// read FIFO and the register state, across several register settings.
// ----------------------------------------------------------------------------
module tb_input_report_ring_with_pending_reads;

    localparam int RDEPTH     = 512;
    localparam int WDEPTH     = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 100;

    typedef struct {
        logic [7:0]        id;
        irr_pkg::status_t  st;
        logic [15:0]       handle;
        logic [11:0]       length;
        logic              last;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  operation;
    logic [15:0] report_handle;
    logic [11:0] report_length;
    logic [7:0]  read_id;
    logic [11:0] read_buffer_length;
    logic        empty;
    logic        pop;
    logic [7:0]  done_read_id;
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic [11:0] out_length;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    int  errors;
    int  idle_cycles;
    bit  pop_enable;
    bit  written_any;

    input_report_ring_with_pending_reads dut (.*);

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    class ring_scoreboard;
        logic [9:0]  qlen;
        bit          polled;
        bit          removed;
        logic [11:0] min_len;
        logic [15:0] handles[RDEPTH];
        logic [11:0] lengths[RDEPTH];
        int          head;
        int          tail;
        int          count;
        logic [7:0]  waiting[$];
        result_t     expected[$];

        function void clear_all();
            qlen = irr_pkg::QLEN_RESET; polled = 0; removed = 0; min_len = 0;
            head = 0; tail = 0; count = 0;
            waiting.delete(); expected.delete();
        endfunction

        function int advance(input int i);
            i++;
            if (i >= qlen) i = 0;
            return i;
        endfunction

        function void write_reg(input irr_pkg::reg_idx_t idx, input logic [11:0] val);
            case (idx)
                irr_pkg::REG_QUEUE_LENGTH:
                    if (val[9:0] >= 2 && val[9:0] <= RDEPTH && val[9:0] != qlen)
                    begin
                        qlen = val[9:0]; head = 0; tail = 0; count = 0;
                    end
                irr_pkg::REG_POLLED_MODE:  polled = val[0];
                irr_pkg::REG_DEV_REMOVED:  removed = val[0];
                irr_pkg::REG_MIN_READ_LEN: min_len = val;
            endcase
        endfunction

        function bit take_oldest(output logic [15:0] h, output logic [11:0] l);
            if (count == 0) return 0;
            h = handles[head]; l = lengths[head];
            head = advance(head); count--;
            return 1;
        endfunction

        function void add(input logic [7:0] id, input irr_pkg::status_t st,
                          input logic [15:0] h, input logic [11:0] l);
            result_t r;
            r.id = id; r.st = st; r.handle = h; r.length = l; r.last = 0;
            expected.push_back(r);
        endfunction

        function void serve(input logic [15:0] h, input logic [11:0] l);
            logic [7:0]  id;
            logic [15:0] sh;
            logic [11:0] sl;
            id = waiting.pop_front();
            if (!take_oldest(sh, sl))
            begin
                sh = h; sl = l;
            end
            add(id, irr_pkg::ST_SUCCESS, sh, sl);
        endfunction

        function void note_request(input irr_pkg::op_t op, input logic [15:0] h,
                                   input logic [11:0] l, input logic [7:0] id,
                                   input logic [11:0] buflen);
            int          n_prior;
            logic [15:0] sh;
            logic [11:0] sl;
            n_prior = expected.size();
            case (op)
                irr_pkg::OP_REPORT:
                    if (!removed)
                    begin
                        if (!polled)
                        begin
                            handles[tail] = h; lengths[tail] = min_len;
                            tail = advance(tail);
                            if (count >= qlen) head = advance(head);
                            else count++;
                            if (waiting.size() > 0) serve(h, min_len);
                        end
                        else
                            while (waiting.size() > 0) serve(h, l);
                    end
                irr_pkg::OP_READ:
                    if (removed) add(id, irr_pkg::ST_DELETE, 0, 0);
                    else if (buflen < min_len) add(id, irr_pkg::ST_SMALL, 0, 0);
                    else if (take_oldest(sh, sl)) add(id, irr_pkg::ST_SUCCESS, sh, sl);
                    else if (waiting.size() >= WDEPTH) add(id, irr_pkg::ST_NOROOM, 0, 0);
                    else
                    begin
                        waiting.push_back(id);
                        add(id, irr_pkg::ST_PENDING, 0, 0);
                    end
                irr_pkg::OP_CANCEL:
                    foreach (waiting[i])
                        if (waiting[i] == id)
                        begin
                            waiting.delete(i);
                            add(id, irr_pkg::ST_CANCELLED, 0, 0);
                            break;
                        end
                irr_pkg::OP_FLUSH:
                    while (waiting.size() > 0)
                        add(waiting.pop_front(), irr_pkg::ST_DELETE, 0, 0);
            endcase
            if (expected.size() > n_prior) expected[expected.size() - 1].last = 1;
        endfunction

        task check_result(input result_t got);
            result_t want;
            if (expected.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result id %0d", got.id));
                return;
            end
            want = expected.pop_front();
            if (got.id !== want.id)
                report_mismatch($sformatf("id %0d, want %0d", got.id, want.id));
            if (got.st !== want.st)
                report_mismatch($sformatf("status %0d, want %0d", got.st, want.st));
            if (got.handle !== want.handle)
                report_mismatch($sformatf("handle %h, want %h", got.handle,
                                          want.handle));
            if (got.length !== want.length)
                report_mismatch($sformatf("length %0d, want %0d", got.length,
                                          want.length));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        endtask
    endclass

    ring_scoreboard board;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random pop with stalls, results checked at the accepting edge.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            result_t got;
            got.id = done_read_id; got.st = irr_pkg::status_t'(status);
            got.handle = out_handle; got.length = out_length; got.last = last;
            board.check_result(got);
        end
        if (!pop_enable) pop <= 1'b0;
        else if ($urandom_range(0, 99) < 70) pop <= 1'b1;
        else pop <= ($urandom_range(0, 99) < 3) ? 1'b0 : 1'b0;
    end

    // Watchdog on cycles without any accepted request, result or register write.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Push stays high between back-to-back requests; drain() lowers it.
    task automatic send_request(input irr_pkg::op_t op, input logic [15:0] h,
                                input logic [11:0] l, input logic [7:0] id,
                                input logic [11:0] buflen);
        int gap;
        gap = random_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        operation <= op;
        report_handle <= h;
        report_length <= l;
        read_id <= id;
        read_buffer_length <= buflen;
        @(posedge clk);
        while (full) @(posedge clk);
        board.note_request(op, h, l, id, buflen);
    endtask

    task automatic write_register(input irr_pkg::reg_idx_t idx, input logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every expected result has arrived and the sequencer has settled.
    task automatic drain();
        push <= 1'b0;
        while (board.expected.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_request(input int read_bias);
        int          r;
        logic [7:0]  id;
        r = $urandom_range(0, 99);
        id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
        if (r < 40)
            send_request(irr_pkg::OP_REPORT, $urandom_range(0, 65535),
                         $urandom_range(0, 4095), $urandom_range(0, 255),
                         $urandom_range(0, 4095));
        else if (r < 40 + read_bias)
            send_request(irr_pkg::OP_READ, $urandom_range(0, 65535),
                         $urandom_range(0, 4095),
                         id, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                             : 12'hFFF - $urandom_range(0, 40));
        else if (r < 94)
            send_request(irr_pkg::OP_CANCEL, $urandom_range(0, 65535),
                         $urandom_range(0, 4095), id, $urandom_range(0, 4095));
        else
            send_request(irr_pkg::OP_FLUSH, $urandom_range(0, 65535),
                         $urandom_range(0, 4095),
                         $urandom_range(0, 255), $urandom_range(0, 4095));
    endtask

    initial
    begin
        board = new();
        board.clear_all();
        errors = 0; idle_cycles = 0; pop_enable = 0; written_any = 0;
        rst_n = 0; push = 0; pop = 0; cfg_valid = 0;
        operation = irr_pkg::OP_REPORT; report_handle = 0; report_length = 0;
        read_id = 0; read_buffer_length = 0; cfg_index = irr_pkg::REG_QUEUE_LENGTH;
        cfg_data = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (5) @(posedge clk);
        pop_enable = 1;

        // Directed part: empty reads wait, reports serve them, cancel and flush.
        send_request(irr_pkg::OP_READ, 0, 0, 8'hFF, 12'hFFF);
        send_request(irr_pkg::OP_READ, 0, 0, 8'h00, 12'h000);
        send_request(irr_pkg::OP_CANCEL, 0, 0, 8'h77, 0);
        send_request(irr_pkg::OP_CANCEL, 0, 0, 8'hFF, 0);
        send_request(irr_pkg::OP_REPORT, 16'hFFFF, 12'hFFF, 0, 0);
        send_request(irr_pkg::OP_REPORT, 16'h0000, 12'h000, 0, 0);
        send_request(irr_pkg::OP_READ, 0, 0, 8'h55, 12'hFFF);
        send_request(irr_pkg::OP_FLUSH, 0, 0, 0, 0);
        for (int i = 0; i < WDEPTH + 1; i++)
            send_request(irr_pkg::OP_READ, 0, 0, i[7:0], 12'hFFF);
        send_request(irr_pkg::OP_FLUSH, 0, 0, 0, 0);
        drain();

        write_register(irr_pkg::REG_MIN_READ_LEN, 12'hFFF);
        write_register(irr_pkg::REG_QUEUE_LENGTH, 12'd2);
        send_request(irr_pkg::OP_READ, 0, 0, 8'hAA, 12'hFFE);
        for (int i = 0; i < 3; i++)
            send_request(irr_pkg::OP_REPORT, 16'h1000 + 16'(i), 12'h0AA, 0, 0);
        send_request(irr_pkg::OP_READ, 0, 0, 8'hAB, 12'hFFF);
        send_request(irr_pkg::OP_READ, 0, 0, 8'hAC, 12'hFFF);
        drain();

        // Polled: one report serves every waiting read.
        write_register(irr_pkg::REG_POLLED_MODE, 12'd1);
        write_register(irr_pkg::REG_MIN_READ_LEN, 12'd0);
        for (int i = 0; i < 4; i++)
            send_request(irr_pkg::OP_READ, 0, 0, 8'h30 + 8'(i), 12'h010);
        send_request(irr_pkg::OP_REPORT, 16'hBEEF, 12'h123, 0, 0);
        drain();

        write_register(irr_pkg::REG_DEV_REMOVED, 12'd1);
        send_request(irr_pkg::OP_READ, 0, 0, 8'h01, 12'hFFF);
        send_request(irr_pkg::OP_REPORT, 16'h1234, 12'h010, 0, 0);
        drain();

        // Random phases under a sweep of register settings, extremes included.
        for (int phase = 0; phase < 8; phase++)
        begin
            logic [11:0] qv;
            case (phase)
                0: qv = 12'd2;
                1: qv = 12'd512;
                2: qv = 12'd3;
                3: qv = 12'(irr_pkg::QLEN_RESET);
                4: qv = 12'd1;
                5: qv = 12'h3FF;
                default: qv = 12'($urandom_range(2, 40));
            endcase
            write_register(irr_pkg::REG_QUEUE_LENGTH, qv);
            write_register(irr_pkg::REG_POLLED_MODE, 12'((phase % 3) == 1));
            write_register(irr_pkg::REG_DEV_REMOVED, 12'(phase == 6));
            write_register(irr_pkg::REG_MIN_READ_LEN,
                           (phase % 2) ? 12'($urandom_range(0, 4095)) : 12'd0);
            for (int k = 0; k < 30; k++)
                random_request((phase % 2) ? 30 : 45);
            drain();
        end

        pop_enable = 0;
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> sim.f
design/irr_pkg.sv
design/irr_front.sv
design/irr_back.sv
design/input_report_ring_with_pending_reads.sv
verif/tb_input_report_ring_with_pending_reads.sv
